@@ sv/ebr_pkg.sv @@
// ----------------------------------------------------------------------------
// ebr_pkg
// Shared types and codes of the Exp-Golomb bit reader: request and status
// codes, payload types and the controller/datapath command and status groups.
// ----------------------------------------------------------------------------
package ebr_pkg;

  // payload types
  typedef logic [2:0]         req_code_t;
  typedef logic [7:0]         byte_t;
  typedef logic [5:0]         bit_count_t;
  typedef logic [31:0]        word_t;
  typedef logic signed [31:0] sword_t;
  typedef logic [1:0]         status_t;
  typedef logic [7:0]         bits_left_t;

  // request codes
  localparam req_code_t REQ_PUSH  = 3'd0;
  localparam req_code_t REQ_READ  = 3'd1;
  localparam req_code_t REQ_UE    = 3'd2;
  localparam req_code_t REQ_SE    = 3'd3;
  localparam req_code_t REQ_CLEAR = 3'd4;

  // status codes
  localparam status_t ST_OK       = 2'd0;
  localparam status_t ST_SHORT    = 2'd1;
  localparam status_t ST_FULL     = 2'd2;
  localparam status_t ST_TOO_LONG = 2'd3;

  // controller to datapath
  typedef struct packed {
    logic fill_en;
    logic take_req;
    logic lzc_en;
    logic align_en;
    logic exec_en;
    logic resp_load;
  } ebr_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic      fill_done;
    logic      out_busy;
    req_code_t req_code;
  } ebr_sts_t;

endpackage

@@ sv/ebr_req_if.sv @@
// ----------------------------------------------------------------------------
// ebr_req_if
// Request channel: valid/ready handshake with request code, byte and length.
// ----------------------------------------------------------------------------
interface ebr_req_if;
  import ebr_pkg::*;

  logic       valid;
  logic       ready;
  req_code_t  req_type;
  byte_t      in_byte;
  bit_count_t bit_count;

  modport source (output valid, output req_type, output in_byte, output bit_count,
                  input ready);
  modport sink   (input valid, input req_type, input in_byte, input bit_count,
                  output ready);
endinterface

@@ sv/ebr_rsp_if.sv @@
// ----------------------------------------------------------------------------
// ebr_rsp_if
// Result channel: valid/ready handshake with values, status and fill level.
// ----------------------------------------------------------------------------
interface ebr_rsp_if;
  import ebr_pkg::*;

  logic       valid;
  logic       ready;
  word_t      value;
  sword_t     signed_value;
  status_t    status;
  bits_left_t bits_left;

  modport source (output valid, output value, output signed_value, output status,
                  output bits_left, input ready);
  modport sink   (input valid, input value, input signed_value, input status,
                  input bits_left, output ready);
endinterface

@@ sv/ebr_ram.sv @@
// ----------------------------------------------------------------------------
// ebr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ebr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                          clk,
  input  logic                                          wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                              wr_data,
  input  logic                                          rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                              rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ sv/ebr_ctrl.sv @@
// ----------------------------------------------------------------------------
// ebr_ctrl
// Request sequencer: takes a request, waits for the bit window to fill,
// steps the decode stages and hands the result to the output register.
// ----------------------------------------------------------------------------
module ebr_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              valid,
  output logic              ready,
  input  ebr_pkg::ebr_sts_t sts,
  output ebr_pkg::ebr_cmd_t cmd
);
  import ebr_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_WAIT  = 3'd1;
  localparam logic [2:0] S_LZC   = 3'd2;
  localparam logic [2:0] S_ALIGN = 3'd3;
  localparam logic [2:0] S_EXEC  = 3'd4;
  localparam logic [2:0] S_RESP  = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  assign ready = (state == S_IDLE);

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        cmd.fill_en  = 1'b1;
        cmd.take_req = valid;
        if (valid) begin
          state_next = S_WAIT;
        end
      end
      S_WAIT: begin
        cmd.fill_en = 1'b1;
        if (sts.fill_done) begin
          case (sts.req_code)
            REQ_UE, REQ_SE:             state_next = S_LZC;
            REQ_PUSH, REQ_READ, REQ_CLEAR: state_next = S_EXEC;
            default:                    state_next = S_IDLE;
          endcase
        end
      end
      S_LZC: begin
        cmd.lzc_en = 1'b1;
        state_next = S_ALIGN;
      end
      S_ALIGN: begin
        cmd.align_en = 1'b1;
        state_next   = S_EXEC;
      end
      S_EXEC: begin
        cmd.exec_en = 1'b1;
        state_next  = S_RESP;
      end
      S_RESP: begin
        if (!sts.out_busy) begin
          cmd.resp_load = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

`ifndef SYNTH
  // a request is never answered in the cycle right after it is taken
  a_no_early_resp: assert property (@(posedge clk) disable iff (rst)
    (valid && ready) |=> !cmd.resp_load)
    else $error("result loaded right after request accept");

  // the decode stages only start from a settled window
  a_lzc_after_fill: assert property (@(posedge clk) disable iff (rst)
    cmd.lzc_en |-> ($past(sts.fill_done) && $past(state) == S_WAIT))
    else $error("leading-zero stage entered without a filled window");
`endif

endmodule

@@ sv/ebr_dp.sv @@
// ----------------------------------------------------------------------------
// ebr_dp
// Datapath: byte RAM holding pushed bytes, a bit window that refills from it
// one byte at a time, leading-zero count, alignment, field extraction and the
// output register.
// ----------------------------------------------------------------------------
module ebr_dp #(
  parameter int STORE_BITS     = 128,
  parameter int MAX_FIELD_BITS = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  ebr_pkg::ebr_cmd_t   cmd,
  output ebr_pkg::ebr_sts_t   sts,
  input  ebr_pkg::req_code_t  req_type,
  input  ebr_pkg::byte_t      in_byte,
  input  ebr_pkg::bit_count_t bit_count,
  output logic                out_valid,
  input  logic                out_ready,
  output ebr_pkg::word_t      value,
  output ebr_pkg::sword_t     signed_value,
  output ebr_pkg::status_t    status,
  output ebr_pkg::bits_left_t bits_left
);
  import ebr_pkg::*;

  localparam int WIN_BITS = 2 * MAX_FIELD_BITS + 8;
  localparam int WCW      = $clog2(WIN_BITS + 1);
  localparam int HW       = $clog2(STORE_BITS + 1);
  localparam int DEPTH    = STORE_BITS / 8;
  localparam int AW       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW       = $clog2(DEPTH + 1);
  localparam int LZW      = $clog2(MAX_FIELD_BITS);
  localparam int NSW      = $clog2(MAX_FIELD_BITS + 1);

  // stream state
  logic [WIN_BITS-1:0] win;
  logic [WCW-1:0]      wc;
  logic [HW-1:0]       held;
  logic [AW-1:0]       rd_ptr;
  logic [AW-1:0]       wr_ptr;
  logic [CW-1:0]       ram_cnt;
  logic                pending;
  byte_t               ram_q;

  // latched request
  req_code_t           req_code;
  byte_t               req_byte;
  logic [NSW-1:0]      req_n;

  // decode stages
  logic [LZW-1:0]            lz;
  logic                      lz_found;
  logic [LZW-1:0]            lz_next;
  logic                      found_next;
  logic [MAX_FIELD_BITS-1:0] aligned;
  logic [WIN_BITS-1:0]       win_shl_lz;

  // result holding register
  word_t      res_value;
  sword_t     res_svalue;
  status_t    res_status;
  bits_left_t res_left;

  // exec outcome
  logic                      do_consume;
  logic                      do_push;
  logic                      do_clear;
  logic [WCW-1:0]            consume_k;
  logic [HW-1:0]             held_after;
  status_t                   ex_status;
  word_t                     ex_value;
  sword_t                    ex_svalue;
  logic [MAX_FIELD_BITS-1:0] field;
  logic [MAX_FIELD_BITS-1:0] top_bits;
  logic [LZW:0]              total;
  logic                      can_issue;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    ptr_inc = (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  assign top_bits = win[WIN_BITS-1 -: MAX_FIELD_BITS];

  // window refill from the byte RAM
  assign can_issue = cmd.fill_en && !pending && (ram_cnt != '0) &&
                     (wc <= WCW'(WIN_BITS - 8));

  assign sts.fill_done = !pending && !((ram_cnt != '0) && (wc <= WCW'(WIN_BITS - 8)));
  assign sts.out_busy  = out_valid && !out_ready;
  assign sts.req_code  = req_code;

  ebr_ram #(
    .WIDTH(8),
    .DEPTH(DEPTH)
  ) u_store (
    .clk    (clk),
    .wr_en  (do_push),
    .wr_addr(wr_ptr),
    .wr_data(req_byte),
    .rd_en  (can_issue),
    .rd_addr(rd_ptr),
    .rd_data(ram_q)
  );

  // leading-zero count over the first field-width bits
  always_comb begin
    lz_next    = '0;
    found_next = |top_bits;
    for (int i = MAX_FIELD_BITS - 1; i >= 0; i--) begin
      if (top_bits[MAX_FIELD_BITS-1-i]) begin
        lz_next = LZW'(i);
      end
    end
  end

  assign win_shl_lz = win << lz;

  // request execution
  always_comb begin
    do_consume = 1'b0;
    do_push    = 1'b0;
    do_clear   = 1'b0;
    consume_k  = '0;
    ex_status  = ST_OK;
    ex_value   = '0;
    ex_svalue  = '0;
    field      = aligned >> (LZW'(MAX_FIELD_BITS - 1) - lz);
    total      = {lz, 1'b1};
    held_after = held;
    if (cmd.exec_en) begin
      case (req_code)
        REQ_PUSH: begin
          if (32'(held) + 32'd8 > 32'(STORE_BITS)) begin
            ex_status = ST_FULL;
          end else begin
            do_push    = 1'b1;
            held_after = held + HW'(8);
          end
        end
        REQ_READ: begin
          if (32'(req_n) > 32'(held)) begin
            ex_status = ST_SHORT;
          end else begin
            ex_value   = 32'(top_bits >> (NSW'(MAX_FIELD_BITS) - req_n));
            do_consume = 1'b1;
            consume_k  = WCW'(req_n);
            held_after = held - HW'(req_n);
          end
        end
        REQ_UE, REQ_SE: begin
          if (!lz_found) begin
            ex_status = (32'(held) >= 32'(MAX_FIELD_BITS)) ? ST_TOO_LONG : ST_SHORT;
          end else if (32'(total) > 32'(held)) begin
            ex_status = ST_SHORT;
          end else begin
            ex_value   = 32'(field) - 32'd1;
            do_consume = 1'b1;
            consume_k  = WCW'(total);
            held_after = held - HW'(total);
            // odd code: (code+1)/2 = field/2, even code: -(code/2) = -(field/2)
            if (req_code == REQ_SE) begin
              ex_svalue = field[0] ? -sword_t'(field >> 1) : sword_t'(field >> 1);
            end
          end
        end
        REQ_CLEAR: begin
          do_clear   = 1'b1;
          held_after = '0;
        end
        default: ex_status = ST_OK;
      endcase
    end
  end

  // request latch and decode stage registers
  always_ff @(posedge clk) begin
    if (rst) begin
      req_code <= REQ_PUSH;
    end else if (cmd.take_req) begin
      req_code <= req_type;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_req) begin
      req_byte <= in_byte;
      req_n    <= (bit_count > 6'(MAX_FIELD_BITS)) ? NSW'(MAX_FIELD_BITS)
                                                    : NSW'(bit_count);
    end
    if (cmd.lzc_en) begin
      lz       <= lz_next;
      lz_found <= found_next;
    end
    if (cmd.align_en) begin
      aligned <= win_shl_lz[WIN_BITS-1 -: MAX_FIELD_BITS];
    end
    if (cmd.exec_en) begin
      res_value  <= ex_value;
      res_svalue <= ex_svalue;
      res_status <= ex_status;
      res_left   <= 8'(held_after);
    end
  end

  // stream state: window, byte queue pointers, fill levels
  always_ff @(posedge clk) begin
    if (rst) begin
      win     <= '0;
      wc      <= '0;
      held    <= '0;
      rd_ptr  <= '0;
      wr_ptr  <= '0;
      ram_cnt <= '0;
      pending <= 1'b0;
    end else if (do_clear) begin
      win     <= '0;
      wc      <= '0;
      held    <= '0;
      rd_ptr  <= '0;
      wr_ptr  <= '0;
      ram_cnt <= '0;
      pending <= 1'b0;
    end else begin
      held <= held_after;
      if (do_consume) begin
        win <= win << consume_k;
        wc  <= wc - consume_k;
      end else if (pending) begin
        win <= win | ({ram_q, {(WIN_BITS - 8){1'b0}}} >> wc);
        wc  <= wc + WCW'(8);
      end
      pending <= can_issue;
      if (can_issue) begin
        rd_ptr  <= ptr_inc(rd_ptr);
        ram_cnt <= ram_cnt - CW'(1);
      end else if (do_push) begin
        wr_ptr  <= ptr_inc(wr_ptr);
        ram_cnt <= ram_cnt + CW'(1);
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.resp_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.resp_load) begin
      value        <= res_value;
      signed_value <= res_svalue;
      status       <= res_status;
      bits_left    <= res_left;
    end
  end

`ifndef SYNTH
  // every held bit sits in the window, the byte queue or the read in flight
  a_bit_balance: assert property (@(posedge clk) disable iff (rst)
    32'(held) == 32'(wc) + 32'(ram_cnt) * 32'd8 + (pending ? 32'd8 : 32'd0))
    else $error("held bit count out of balance with window and queue");

  // window and store never overfill
  a_win_bound: assert property (@(posedge clk) disable iff (rst)
    32'(wc) <= 32'(WIN_BITS) && 32'(held) <= 32'(STORE_BITS))
    else $error("window or store fill level over capacity");

  // failed requests return zero values
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != ST_OK) |-> (value == '0 && signed_value == '0))
    else $error("nonzero value on an error result");
`endif

endmodule

@@ sv/exp_golomb_bit_reader_core.sv @@
// ----------------------------------------------------------------------------
// exp_golomb_bit_reader_core
// MSB-first bitstream reader: byte pushes, fixed-length reads, clears and unsigned and
// signed Exp-Golomb decodes over a bounded bit store.
//
//   channel | dir | payload
//   --------+-----+------------------------------------------------
//   req     | in  | req_type[2:0], in_byte[7:0], bit_count[5:0]
//   rsp     | out | value[31:0], signed_value[31:0], status[1:0],
//           |     | bits_left[7:0]
//
// Push, clear and fixed reads go from accept through wait, execute and result
// back to idle; ue and se add leading-zero and align. Wait lasts while bytes
// move from the byte RAM into the window (one RAM read port, one byte per read).
// The window refills while the block waits for a request.
// Reset is synchronous; the store comes up empty with no clearing pass.
// A beat on rsp may stall; the next request is taken meanwhile and its
// result waits until the output register frees.
// ----------------------------------------------------------------------------
module exp_golomb_bit_reader_core #(
  parameter int STORE_BITS     = 128,
  parameter int MAX_FIELD_BITS = 32
) (
  input logic       clk,
  input logic       rst,
  ebr_req_if.sink   req,
  ebr_rsp_if.source rsp
);
  import ebr_pkg::*;

  ebr_cmd_t cmd;
  ebr_sts_t sts;

  // sequencer
  ebr_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .valid(req.valid),
    .ready(req.ready),
    .sts  (sts),
    .cmd  (cmd)
  );

  // bit store and decode datapath
  ebr_dp #(
    .STORE_BITS    (STORE_BITS),
    .MAX_FIELD_BITS(MAX_FIELD_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .req_type    (req.req_type),
    .in_byte     (req.in_byte),
    .bit_count   (req.bit_count),
    .out_valid   (rsp.valid),
    .out_ready   (rsp.ready),
    .value       (rsp.value),
    .signed_value(rsp.signed_value),
    .status      (rsp.status),
    .bits_left   (rsp.bits_left)
  );

endmodule
